/* sv/version_negotiation_packet_parser_assert.svh */
// ----------------------------------------------------------------------------
// Version negotiation packet parser assertion macros
// Short forms for clocked implication checks under synchronous reset.
// ----------------------------------------------------------------------------
`ifndef VERSION_NEGOTIATION_PACKET_PARSER_ASSERT_SVH
`define VERSION_NEGOTIATION_PACKET_PARSER_ASSERT_SVH

// same-cycle implication
`define VNP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vnp assertion failed");

// next-cycle implication
`define VNP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vnp assertion failed");

`endif

/* sv/vnp_pkg.sv */
// ----------------------------------------------------------------------------
// Version negotiation packet parser package
// Byte roles, status codes and sizing constants shared by the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vnp_pkg;

  // largest packet length before the too-long status is raised
  localparam int unsigned MAX_PACKET_LENGTH = 65535;
  // shortest legal packet
  localparam int unsigned MIN_PACKET_LENGTH = 7;
  // last byte position of the version word
  localparam int unsigned VERSION_LAST_POS  = 4;
  // reset value of the connection id length limit
  localparam logic [7:0]  CID_LEN_RESET     = 8'd20;
  // long-form header bit of the first byte
  localparam logic [7:0]  LONG_FORM_MASK    = 8'h80;

  // parse phase, also the byte role reported on the result
  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_VERSION = 3'd1,
    PH_DLEN    = 3'd2,
    PH_DCID    = 3'd3,
    PH_SLEN    = 3'd4,
    PH_SCID    = 3'd5,
    PH_LIST    = 3'd6
  } phase_t;

  // byte role reported once an error has been found
  localparam logic [2:0] KIND_IGNORED = 3'd7;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_NOT_LONG = 3'd2,
    ST_VERSION  = 3'd3,
    ST_CID_LONG = 3'd4,
    ST_TRUNC    = 3'd5,
    ST_BAD_LIST = 3'd6,
    ST_TOO_LONG = 3'd7
  } status_t;

endpackage

`default_nettype wire

/* sv/version_negotiation_packet_parser.sv */
// ----------------------------------------------------------------------------
// Version negotiation packet parser
// Streams a version negotiation packet byte by byte, tags each byte and
// reports a verdict with the id lengths and version count on the last byte.
// ----------------------------------------------------------------------------
// Takes one byte item per clock cycle while results are taken, and gives one
// result item per byte. An accepted item sits in an input register and its
// result is loaded into the result register once that register is empty or
// taken; parse state is updated in the single step between the two registers,
// which sets the one-item-per-cycle rate. Backpressure on the result side holds
// both registers; the input side stalls only when both are full. The id length
// limit (cfg_wr_data) should be written while no packet is in flight; its reset
// value is 20.
`timescale 1ns / 1ps
`default_nettype none
`include "version_negotiation_packet_parser_assert.svh"

module version_negotiation_packet_parser
  import vnp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  // byte items in
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last,
  // result items out
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_byte_kind,
  output logic             out_done_res,
  output logic [2:0]       out_status,
  output logic [7:0]       out_dest_cid_length,
  output logic [7:0]       out_source_cid_length,
  output logic [13:0]      out_version_count
);

  // configuration register
  logic [7:0] max_cid_len_r;

  // input stage
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // parse state
  phase_t     phase_r, phase_nxt;
  logic [15:0] byte_pos_r, byte_pos_nxt;
  logic [7:0] cid_left_r, cid_left_nxt;
  logic [7:0] dlen_r, dlen_nxt;
  logic [7:0] slen_r, slen_nxt;
  logic [15:0] list_cnt_r, list_cnt_nxt;
  status_t    err_r, err_nxt;

  // result stage
  logic        out_valid_r;
  logic [2:0]  out_kind_r, out_kind_nxt;
  logic        out_done_r;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [7:0]  out_dlen_r, out_dlen_nxt;
  logic [7:0]  out_slen_r, out_slen_nxt;
  logic [13:0] out_count_r, out_count_nxt;

  logic out_adv;
  logic in_adv;
  logic step;

  // handshake: result register moves when empty or taken
  assign out_adv  = !out_valid_r || !out_stall;
  assign in_adv   = !in_valid_r || out_adv;
  assign in_stall = !in_adv;
  assign step     = in_valid_r && out_adv;

  // configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cid_len_r <= CID_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_cid_len_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_adv) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && in_valid) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_last;
    end
  end

  // parse one byte and build its result
  always_comb begin
    status_t     st;
    logic [16:0] length;
    phase_nxt      = phase_r;
    byte_pos_nxt   = byte_pos_r;
    cid_left_nxt   = cid_left_r;
    dlen_nxt       = dlen_r;
    slen_nxt       = slen_r;
    list_cnt_nxt   = list_cnt_r;
    err_nxt        = err_r;
    out_kind_nxt   = KIND_IGNORED;
    out_status_nxt = ST_OK;
    out_dlen_nxt   = '0;
    out_slen_nxt   = '0;
    out_count_nxt  = '0;
    st             = ST_OK;

    // too long before any parsing of this byte
    if ({16'd0, byte_pos_r} >= 32'(MAX_PACKET_LENGTH) && err_nxt == ST_OK) begin
      err_nxt = ST_TOO_LONG;
    end

    if (err_nxt == ST_OK) begin
      out_kind_nxt = phase_r;
      unique case (phase_r)
        PH_FIRST: begin
          if ((in_byte_r & LONG_FORM_MASK) == 8'd0) err_nxt = ST_NOT_LONG;
          phase_nxt = PH_VERSION;
        end
        PH_VERSION: begin
          if (in_byte_r != 8'd0) err_nxt = ST_VERSION;
          if (byte_pos_r >= 16'(VERSION_LAST_POS)) phase_nxt = PH_DLEN;
        end
        PH_DLEN: begin
          dlen_nxt     = in_byte_r;
          if (in_byte_r > max_cid_len_r) err_nxt = ST_CID_LONG;
          cid_left_nxt = in_byte_r;
          phase_nxt    = (in_byte_r != 8'd0) ? PH_DCID : PH_SLEN;
        end
        PH_DCID: begin
          cid_left_nxt = cid_left_r - 8'd1;
          if (cid_left_nxt == 8'd0) phase_nxt = PH_SLEN;
        end
        PH_SLEN: begin
          slen_nxt     = in_byte_r;
          if (in_byte_r > max_cid_len_r) err_nxt = ST_CID_LONG;
          cid_left_nxt = in_byte_r;
          phase_nxt    = (in_byte_r != 8'd0) ? PH_SCID : PH_LIST;
        end
        PH_SCID: begin
          cid_left_nxt = cid_left_r - 8'd1;
          if (cid_left_nxt == 8'd0) phase_nxt = PH_LIST;
        end
        default: begin
          if (list_cnt_r != 16'hFFFF) list_cnt_nxt = list_cnt_r + 16'd1;
        end
      endcase
    end

    // byte counter saturates
    length = {1'b0, byte_pos_r} + 17'd1;
    if (byte_pos_r != 16'hFFFF) byte_pos_nxt = byte_pos_r + 16'd1;

    // verdict on the last byte, then clear for the next packet
    if (in_last_r) begin
      if (err_nxt == ST_OK) begin
        if (phase_nxt != PH_LIST) begin
          err_nxt = ST_TRUNC;
        end else if (list_cnt_nxt == 16'd0 || list_cnt_nxt[1:0] != 2'd0) begin
          err_nxt = ST_BAD_LIST;
        end
      end
      st = err_nxt;
      if (length < 17'(MIN_PACKET_LENGTH)) st = ST_SHORT;
      out_status_nxt = st;
      out_dlen_nxt   = dlen_nxt;
      out_slen_nxt   = slen_nxt;
      if (st == ST_OK) out_count_nxt = list_cnt_nxt[15:2];
      phase_nxt    = PH_FIRST;
      byte_pos_nxt = '0;
      cid_left_nxt = '0;
      dlen_nxt     = '0;
      slen_nxt     = '0;
      list_cnt_nxt = '0;
      err_nxt      = ST_OK;
    end
  end

  // parse state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_FIRST;
      byte_pos_r <= '0;
      cid_left_r <= '0;
      dlen_r     <= '0;
      slen_r     <= '0;
      list_cnt_r <= '0;
      err_r      <= ST_OK;
    end else if (step) begin
      phase_r    <= phase_nxt;
      byte_pos_r <= byte_pos_nxt;
      cid_left_r <= cid_left_nxt;
      dlen_r     <= dlen_nxt;
      slen_r     <= slen_nxt;
      list_cnt_r <= list_cnt_nxt;
      err_r      <= err_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_kind_r   <= out_kind_nxt;
      out_done_r   <= in_last_r;
      out_status_r <= out_status_nxt;
      out_dlen_r   <= out_dlen_nxt;
      out_slen_r   <= out_slen_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_byte_kind         = out_kind_r;
  assign out_done_res          = out_done_r;
  assign out_status            = out_status_r;
  assign out_dest_cid_length   = out_dlen_r;
  assign out_source_cid_length = out_slen_r;
  assign out_version_count     = out_count_r;

  // checks
  `VNP_ASSERT_IMP(a_mid_result_clear, out_valid_r && !out_done_r,
    out_status_r == ST_OK && out_dlen_r == 8'd0 && out_slen_r == 8'd0 &&
    out_count_r == 14'd0)
  `VNP_ASSERT_IMP(a_count_only_ok, out_valid_r && out_status_r != ST_OK,
    out_count_r == 14'd0)
  `VNP_ASSERT_NXT(a_last_clears, step && in_last_r,
    phase_r == PH_FIRST && byte_pos_r == 16'd0 && err_r == ST_OK)
  `VNP_ASSERT_IMP(a_stall_when_full, in_stall, in_valid_r && out_valid_r)

endmodule

`default_nettype wire

/* verif/tb_version_negotiation_packet_parser.sv */
// ----------------------------------------------------------------------------
// Version negotiation packet parser testbench
// Streams packets into the parser through a byte-wide valid/stall channel
// and predicts every result: a short directed table, then random packets
// under several id length limits.
// Each result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_version_negotiation_packet_parser;
  import vnp_pkg::*;

  // cycles with no item moving on either side before the run is abandoned
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  // random items sent under each id length limit
  localparam int unsigned ITEMS_PER_LIMIT = 140;

  // one result item as the parser reports it
  typedef struct packed {
    logic [2:0]  kind;
    logic        done;
    status_t     status;
    logic [7:0]  dest_len;
    logic [7:0]  src_len;
    logic [13:0] ver_count;
  } byte_verdict_t;

  // directed row: byte, last mark, and a typed-in verdict where one is given
  typedef struct packed {
    logic [7:0]    data;
    logic          last_flag;
    logic          typed;
    byte_verdict_t want;
  } stim_row_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_RUNS
  } stall_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_byte_kind;
  logic        out_done_res;
  logic [2:0]  out_status;
  logic [7:0]  out_dest_cid_length;
  logic [7:0]  out_source_cid_length;
  logic [13:0] out_version_count;

  // parser state as predicted
  logic [7:0]  cid_limit;
  phase_t      cur_phase;
  logic [15:0] pkt_pos;
  logic [7:0]  cid_left;
  logic [7:0]  dest_len_seen;
  logic [7:0]  src_len_seen;
  logic [15:0] list_bytes;
  status_t     first_error;

  byte_verdict_t pending_verdicts[$];
  int unsigned   mismatch_count = 0;
  int unsigned   items_sent = 0;
  int unsigned   burst_left = 0;
  int unsigned   idle_cycles = 0;

  stall_mode_t stall_mode = STALL_NONE;
  int unsigned stall_span = 0;
  int unsigned stall_run = 0;
  logic        stall_hold = 1'b0;
  logic        stall_now;

  // directed packets
  stim_row_t directed_rows [26] = '{
    // one byte without the long-form bit: short wins over not long
    '{8'h00, 1'b1, 1'b1, '{PH_FIRST, 1'b1, ST_SHORT, 8'd0, 8'd0, 14'd0}},
    // smallest good packet: empty ids, one listed version
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b1, '{PH_LIST, 1'b1, ST_OK, 8'd0, 8'd0, 14'd1}},
    // dcid length 255 over the reset limit, the byte after it is ignored
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h5A, 1'b1, 1'b1, '{KIND_IGNORED, 1'b1, ST_CID_LONG, 8'd255, 8'd0, 14'd0}},
    // ends on the scid length byte: the version list is empty
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, '{PH_SLEN, 1'b1, ST_BAD_LIST, 8'd0, 8'd0, 14'd0}}
  };

  version_negotiation_packet_parser u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_data_byte          (in_data_byte),
    .in_last               (in_last),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_byte_kind         (out_byte_kind),
    .out_done_res          (out_done_res),
    .out_status            (out_status),
    .out_dest_cid_length   (out_dest_cid_length),
    .out_source_cid_length (out_source_cid_length),
    .out_version_count     (out_version_count)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // per-packet state back to the first byte
  function automatic void clear_packet_state();
    cur_phase     = PH_FIRST;
    pkt_pos       = 16'd0;
    cid_left      = 8'd0;
    dest_len_seen = 8'd0;
    src_len_seen  = 8'd0;
    list_bytes    = 16'd0;
    first_error   = ST_OK;
  endfunction

  // only the first error of a packet sticks
  function automatic void note_error(status_t code);
    if (first_error == ST_OK) begin
      first_error = code;
    end
  endfunction

  // predicted verdict for one byte, advancing the parse state
  function automatic byte_verdict_t parse_byte(logic [7:0] data, logic last_flag);
    byte_verdict_t v;
    logic [16:0]   pkt_len;
    v = '0;
    if (pkt_pos >= MAX_PACKET_LENGTH) begin
      note_error(ST_TOO_LONG);
    end
    if (first_error != ST_OK) begin
      v.kind = KIND_IGNORED;
    end else begin
      v.kind = cur_phase;
      case (cur_phase)
        PH_FIRST: begin
          if ((data & LONG_FORM_MASK) == 8'd0) begin
            note_error(ST_NOT_LONG);
          end
          cur_phase = PH_VERSION;
        end
        PH_VERSION: begin
          if (data != 8'd0) begin
            note_error(ST_VERSION);
          end
          if (pkt_pos >= VERSION_LAST_POS) begin
            cur_phase = PH_DLEN;
          end
        end
        PH_DLEN: begin
          dest_len_seen = data;
          if (data > cid_limit) begin
            note_error(ST_CID_LONG);
          end
          cid_left  = data;
          cur_phase = (data != 8'd0) ? PH_DCID : PH_SLEN;
        end
        PH_DCID: begin
          cid_left = cid_left - 8'd1;
          if (cid_left == 8'd0) begin
            cur_phase = PH_SLEN;
          end
        end
        PH_SLEN: begin
          src_len_seen = data;
          if (data > cid_limit) begin
            note_error(ST_CID_LONG);
          end
          cid_left  = data;
          cur_phase = (data != 8'd0) ? PH_SCID : PH_LIST;
        end
        PH_SCID: begin
          cid_left = cid_left - 8'd1;
          if (cid_left == 8'd0) begin
            cur_phase = PH_LIST;
          end
        end
        default: begin
          if (list_bytes != 16'hFFFF) begin
            list_bytes = list_bytes + 16'd1;
          end
        end
      endcase
    end

    // byte counter saturates at its top value
    pkt_len = {1'b0, pkt_pos} + 17'd1;
    if (pkt_pos != 16'hFFFF) begin
      pkt_pos = pkt_pos + 16'd1;
    end

    // verdict on the final byte
    if (last_flag) begin
      if (first_error == ST_OK) begin
        if (cur_phase != PH_LIST) begin
          note_error(ST_TRUNC);
        end else if (list_bytes == 16'd0 || list_bytes[1:0] != 2'd0) begin
          note_error(ST_BAD_LIST);
        end
      end
      v.done   = 1'b1;
      v.status = first_error;
      if (pkt_len < MIN_PACKET_LENGTH) begin
        v.status = ST_SHORT;
      end
      v.dest_len = dest_len_seen;
      v.src_len  = src_len_seen;
      if (v.status == ST_OK) begin
        v.ver_count = list_bytes[15:2];
      end
      clear_packet_state();
    end
    return v;
  endfunction

  // offer one byte, with bursts and gaps on the sending side
  task automatic send_byte(input logic [7:0] data, input logic last_flag,
                           input logic typed, input byte_verdict_t want);
    byte_verdict_t v;
    int unsigned   gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_last      <= last_flag;
    do @(posedge clk); while (in_stall);
    v = parse_byte(data, last_flag);
    pending_verdicts.push_back(typed ? want : v);
    items_sent++;
  endtask

  // send a whole packet, marking its final byte
  task automatic send_bytes(input logic [7:0] pkt[$]);
    for (int i = 0; i < pkt.size(); i++) begin
      send_byte(pkt[i], i == pkt.size() - 1, 1'b0, '0);
    end
  endtask

  // stop sending and wait for every predicted result, then settle
  task automatic drain_results(input int unsigned settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // change the id length limit with the parser idle
  task automatic write_cid_limit(input logic [7:0] value);
    drain_results(4);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cid_limit = value;
  endtask

  // id length within the limit (at most 20) mostly, at or just over it sometimes, anything now and then
  function automatic logic [7:0] pick_cid_len();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) begin
      return 8'($urandom_range(0, (cid_limit < 8'd20) ? cid_limit : 20));
    end else if (roll < 9) begin
      return (roll == 6 || cid_limit == 8'hFF) ? cid_limit : cid_limit + 8'd1;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly well-formed packets, some broken on purpose, some noise
  task automatic send_random_packet();
    logic [7:0]  pkt[$];
    logic [7:0]  len;
    int unsigned roll;
    int unsigned n;
    int unsigned cut;
    roll = $urandom_range(0, 99);
    if (roll >= 92) begin
      // runt packets or line noise of up to 24 bytes
      n = (roll >= 96) ? $urandom_range(1, 24) : $urandom_range(1, 6);
      repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
    end else begin
      pkt.push_back(8'($urandom_range(0, 255)) | LONG_FORM_MASK);
      repeat (4) pkt.push_back(8'h00);
      repeat (2) begin
        len = pick_cid_len();
        pkt.push_back(len);
        repeat (len) pkt.push_back(8'($urandom_range(0, 255)));
      end
      n = 4 * $urandom_range(1, 6);
      // list empty or not a whole number of versions
      if (roll >= 84) begin
        n = ($urandom_range(0, 3) == 0) ? 0 : n - $urandom_range(1, 3);
      end
      repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
      if (roll >= 60 && roll < 68) begin
        pkt[0] = pkt[0] & ~LONG_FORM_MASK;
      end else if (roll >= 68 && roll < 76) begin
        pkt[$urandom_range(1, 4)] = 8'($urandom_range(1, 255));
      end else if (roll >= 76 && roll < 84) begin
        cut = $urandom_range(1, pkt.size() - 1);
        while (pkt.size() > cut) void'(pkt.pop_back());
      end
    end
    send_bytes(pkt);
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // result side stalls: none, random, or runs of fixed state
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      stall_span = $urandom_range(32, 256);
    end
    stall_span--;
    case (stall_mode)
      STALL_NONE: begin
        stall_now = 1'b0;
      end
      STALL_RANDOM: begin
        stall_now = ($urandom_range(0, 3) == 0);
      end
      default: begin
        if (stall_run == 0) begin
          stall_hold = ~stall_hold;
          stall_run  = $urandom_range(1, 12);
        end
        stall_run--;
        stall_now = stall_hold;
      end
    endcase
    out_stall <= stall_now;
  end

  // check each accepted result against the oldest prediction
  always @(posedge clk) begin
    byte_verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result, kind %0d status %0d", $time, out_byte_kind,
                 out_status);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        compare_field("byte_kind", want.kind, out_byte_kind);
        compare_field("done_res", want.done, out_done_res);
        compare_field("status", want.status, out_status);
        compare_field("dest_cid_length", want.dest_len, out_dest_cid_length);
        compare_field("source_cid_length", want.src_len, out_source_cid_length);
        compare_field("version_count", want.ver_count, out_version_count);
      end
    end
  end

  // watchdog on cycles where no item moves
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin
    int unsigned start_items;
    cid_limit = CID_LEN_RESET;
    clear_packet_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed table under the reset limit
    for (int i = 0; i < 26; i++) begin
      send_byte(directed_rows[i].data, directed_rows[i].last_flag,
                directed_rows[i].typed, directed_rows[i].want);
    end

    // random packets under zero, full and a random limit
    for (int k = 0; k < 3; k++) begin
      case (k)
        0: write_cid_limit(8'd0);
        1: write_cid_limit(8'hFF);
        default: write_cid_limit(8'($urandom_range(1, 254)));
      endcase
      start_items = items_sent;
      while (items_sent - start_items < ITEMS_PER_LIMIT) send_random_packet();
    end

    drain_results(8);
    if (pending_verdicts.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_verdicts.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
